### rtl/lcpb_pkg.sv
// package: shared constants and the tanh breakpoint table for the lstm backward cell
`timescale 1ns / 1ps
`default_nettype none
package lcpb_pkg;

  localparam int unsigned QONE = 4096;
  localparam int unsigned NGATE = 4;
  localparam logic [12:0] TANH_SAT = 13'd4093;

  function automatic logic [12:0] tanh_tab(input logic [4:0] k);
    logic [12:0] r;
    unique case (k)
      5'd0: r = 13'd0;
      5'd1: r = 13'd1003;
      5'd2: r = 13'd1893;
      5'd3: r = 13'd2602;
      5'd4: r = 13'd3119;
      5'd5: r = 13'd3475;
      5'd6: r = 13'd3707;
      5'd7: r = 13'd3856;
      5'd8: r = 13'd3949;
      5'd9: r = 13'd4006;
      5'd10: r = 13'd4041;
      5'd11: r = 13'd4062;
      5'd12: r = 13'd4076;
      5'd13: r = 13'd4084;
      5'd14: r = 13'd4089;
      5'd15: r = 13'd4091;
      5'd16: r = 13'd4093;
      default: r = 13'd4093;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/lstm_cell_pointwise_backward.sv
// top level: pipelined lstm pointwise backward step with bias gradient accumulators
//
// channel  | handshake                    | payload
// request  | in_valid_i / in_ready_o      | hidden_index_i .. carried_cell_grad_i
// result   | out_valid_o / out_ready_i    | grad_pre_*_o, prev_cell_grad_o, bias_sum_*_o, saturated_o
//
// one request per cycle, except while the pipeline holds
// the whole pipeline advances together and holds while a result waits for out_ready_i
// after reset a clearing pass zeroes the accumulator memory, one entry at a time,
// during which no request is taken
// accumulator read-modify-write spans two stages, with forwarding between neighbors
`timescale 1ns / 1ps
`default_nettype none
module lstm_cell_pointwise_backward #(
  parameter int unsigned HIDDEN_MAX = 1024
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire        [9:0]  hidden_index_i,
  input  wire signed [15:0] prev_cell_i,
  input  wire        [12:0] input_gate_i,
  input  wire signed [13:0] cand_gate_i,
  input  wire        [12:0] forget_gate_i,
  input  wire        [12:0] output_gate_i,
  input  wire signed [15:0] new_cell_i,
  input  wire signed [15:0] out_hidden_grad_i,
  input  wire signed [15:0] carried_hidden_grad_i,
  input  wire signed [15:0] cell_out_grad_i,
  input  wire signed [15:0] carried_cell_grad_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] grad_pre_input_o,
  output logic signed [15:0] grad_pre_cand_o,
  output logic signed [15:0] grad_pre_forget_o,
  output logic signed [15:0] grad_pre_output_o,
  output logic signed [15:0] prev_cell_grad_o,
  output logic signed [31:0] bias_sum_input_o,
  output logic signed [31:0] bias_sum_cand_o,
  output logic signed [31:0] bias_sum_forget_o,
  output logic signed [31:0] bias_sum_output_o,
  output logic              saturated_o
);
  import lcpb_pkg::*;

  localparam int unsigned AW = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;

  logic adv;
  logic [12:1] v_q;
  logic clr_q;
  logic [AW-1:0] clr_cnt_q;

  // index carried down the pipe
  logic [AW-1:0] addr_q [2:11];
  logic inr_q [2:11];

  // stage 1 input registers
  logic [AW-1:0] s1_addr_q;
  logic s1_inr_q;
  logic signed [15:0] s1_cp_q, s1_cn_q, s1_ohg_q, s1_chg_q, s1_cog_q, s1_ccg_q;
  logic [12:0] s1_gi_q, s1_gf_q, s1_go_q;
  logic signed [13:0] s1_gg_q;

  // stage 1 logic
  logic signed [16:0] s1_dh, s1_cs, s1_a;
  logic s1_big, s1_neg;
  logic [12:0] s1_tk, s1_tk1;
  logic [9:0] s1_d;
  logic [19:0] s1_tprod;
  logic signed [13:0] s1_gis, s1_gfs, s1_gos;
  logic signed [27:0] s1_pi, s1_pf, s1_po, s1_pg;
  logic signed [30:0] s1_pdct;

  always_comb begin
    s1_dh = 17'(s1_ohg_q) + 17'(s1_chg_q);
    s1_cs = 17'(s1_cog_q) + 17'(s1_ccg_q);
    s1_neg = s1_cn_q[15];
    s1_a = s1_neg ? -17'(s1_cn_q) : 17'(s1_cn_q);
    s1_big = s1_a[16] | s1_a[15] | s1_a[14];
    s1_tk = tanh_tab({1'b0, s1_a[13:10]});
    s1_tk1 = tanh_tab(5'({1'b0, s1_a[13:10]}) + 5'd1);
    s1_d = 10'(s1_tk1 - s1_tk);
    s1_tprod = 20'(s1_d) * 20'(s1_a[9:0]);
    s1_gis = $signed({1'b0, s1_gi_q});
    s1_gfs = $signed({1'b0, s1_gf_q});
    s1_gos = $signed({1'b0, s1_go_q});
    s1_pi = 28'(s1_gis) * 28'(14'sd4096 - s1_gis);
    s1_pf = 28'(s1_gfs) * 28'(14'sd4096 - s1_gfs);
    s1_po = 28'(s1_gos) * 28'(14'sd4096 - s1_gos);
    s1_pg = 28'(s1_gg_q) * 28'(s1_gg_q);
    s1_pdct = 31'(s1_gos) * 31'(s1_dh);
  end

  // stage 2
  logic signed [15:0] cp_q [2:7];
  logic signed [13:0] gi_q [2:7], gf_q [2:7], gg_q [2:7];
  logic signed [16:0] cs_q [2:6];
  logic signed [16:0] s2_dh_q;
  logic s2_neg_q, s2_big_q;
  logic [12:0] s2_tk_q;
  logic [19:0] s2_tprod_q;
  logic signed [27:0] s2_pi_q, s2_pf_q, s2_po_q, s2_pg_q;
  logic signed [30:0] s2_pdct_q;

  logic [10:0] s2_frac;
  logic [12:0] s2_mag;
  logic signed [13:0] s2_ct;
  logic signed [18:0] s2_dct;
  logic signed [15:0] s2_ip, s2_fp, s2_op, s2_gc;

  always_comb begin
    s2_frac = 11'(({1'b0, s2_tprod_q} + 21'd512) >> 10);
    s2_mag = s2_big_q ? TANH_SAT : 13'(s2_tk_q + 13'(s2_frac));
    s2_ct = s2_neg_q ? -$signed({1'b0, s2_mag}) : $signed({1'b0, s2_mag});
    s2_dct = 19'((s2_pdct_q + 31'sd2048) >>> 12);
    s2_ip = 16'((s2_pi_q + 28'sd2048) >>> 12);
    s2_fp = 16'((s2_pf_q + 28'sd2048) >>> 12);
    s2_op = 16'((s2_po_q + 28'sd2048) >>> 12);
    s2_gc = 16'sd4096 - 16'((s2_pg_q + 28'sd2048) >>> 12);
  end

  // stage 3
  logic signed [15:0] ip_q [3:9], fp_q [3:9], op_q [3:9], gc_q [3:9];
  logic signed [13:0] s3_ct_q;
  logic signed [18:0] dct_q [3:5];
  logic signed [16:0] s3_dh_q;
  logic signed [27:0] s3_pcc;
  logic signed [30:0] s3_pcd;

  always_comb begin
    s3_pcc = 28'(s3_ct_q) * 28'(s3_ct_q);
    s3_pcd = 31'(s3_ct_q) * 31'(s3_dh_q);
  end

  // stage 4
  logic signed [27:0] s4_pcc_q;
  logic signed [30:0] s4_pcd_q;
  logic signed [14:0] s4_tc;
  logic signed [18:0] s4_do;

  always_comb begin
    s4_tc = 15'sd4096 - 15'((s4_pcc_q + 28'sd2048) >>> 12);
    s4_do = 19'((s4_pcd_q + 31'sd2048) >>> 12);
  end

  // stage 5
  logic signed [18:0] do_q [5:9];
  logic signed [14:0] s5_tc_q;
  logic signed [33:0] s5_ptd;

  assign s5_ptd = 34'(s5_tc_q) * 34'(dct_q[5]);

  // stage 6
  logic signed [33:0] s6_ptd_q;
  logic signed [22:0] s6_dc;

  assign s6_dc = 23'(cs_q[6]) + 23'((s6_ptd_q + 34'sd2048) >>> 12);

  // stage 7
  logic signed [22:0] s7_dc_q;
  logic signed [39:0] s7_pf, s7_pcp, s7_pi, s7_pg;

  always_comb begin
    s7_pf = 40'(cp_q[7]) * 40'(s7_dc_q);
    s7_pcp = 40'(gf_q[7]) * 40'(s7_dc_q);
    s7_pi = 40'(gg_q[7]) * 40'(s7_dc_q);
    s7_pg = 40'(gi_q[7]) * 40'(s7_dc_q);
  end

  // stage 8
  logic signed [39:0] s8_pf_q, s8_pcp_q, s8_pi_q, s8_pg_q;
  logic signed [27:0] s8_df, s8_dcp, s8_di, s8_dgc;

  always_comb begin
    s8_df = 28'((s8_pf_q + 40'sd2048) >>> 12);
    s8_dcp = 28'((s8_pcp_q + 40'sd2048) >>> 12);
    s8_di = 28'((s8_pi_q + 40'sd2048) >>> 12);
    s8_dgc = 28'((s8_pg_q + 40'sd2048) >>> 12);
  end

  // stage 9
  logic signed [27:0] s9_df_q, s9_di_q, s9_dgc_q;
  logic signed [27:0] dcp_q [9:10];
  logic signed [43:0] s9_qi, s9_qg, s9_qf, s9_qo;

  always_comb begin
    s9_qi = 44'(ip_q[9]) * 44'(s9_di_q);
    s9_qg = 44'(gc_q[9]) * 44'(s9_dgc_q);
    s9_qf = 44'(fp_q[9]) * 44'(s9_df_q);
    s9_qo = 44'(op_q[9]) * 44'(do_q[9]);
  end

  // stage 10
  logic signed [43:0] s10_q_q [4];
  logic signed [31:0] s10_r [5];
  logic signed [15:0] s10_res [5];
  logic s10_flag;

  always_comb begin
    s10_flag = 1'b0;
    for (int g = 0; g < 4; g++) begin
      s10_r[g] = 32'((s10_q_q[g] + 44'sd2048) >>> 12);
    end
    s10_r[4] = 32'(dcp_q[10]);
    for (int g = 0; g < 5; g++) begin
      if (s10_r[g] > 32'sd32767) begin
        s10_res[g] = 16'sh7fff;
        s10_flag = 1'b1;
      end else if (s10_r[g] < -32'sd32768) begin
        s10_res[g] = 16'sh8000;
        s10_flag = 1'b1;
      end else begin
        s10_res[g] = 16'(s10_r[g]);
      end
    end
  end

  // stage 11: accumulate
  logic signed [15:0] s11_res_q [5];
  logic s11_flag_q;
  logic [127:0] mem_rd_q, fwd_val_q;
  logic fwd_q;
  logic [127:0] s11_old, s11_row;
  logic signed [32:0] s11_wide [4];
  logic signed [31:0] s11_sum [4];
  logic s11_flag;

  always_comb begin
    s11_old = fwd_q ? fwd_val_q : mem_rd_q;
    s11_flag = s11_flag_q;
    for (int g = 0; g < 4; g++) begin
      s11_wide[g] = 33'($signed(s11_old[32*g +: 32])) + 33'(s11_res_q[g]);
      if (s11_wide[g] > 33'sd2147483647) begin
        s11_sum[g] = 32'sh7fffffff;
        s11_flag = s11_flag | inr_q[11];
      end else if (s11_wide[g] < -33'sd2147483648) begin
        s11_sum[g] = 32'sh80000000;
        s11_flag = s11_flag | inr_q[11];
      end else begin
        s11_sum[g] = 32'(s11_wide[g]);
      end
    end
    s11_row = {s11_sum[3], s11_sum[2], s11_sum[1], s11_sum[0]};
  end

  // accumulator memory
  logic [127:0] bmem [HIDDEN_MAX];
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [127:0] mem_wd;

  always_comb begin
    mem_we = clr_q | (adv & v_q[11] & inr_q[11]);
    mem_wa = clr_q ? clr_cnt_q : addr_q[11];
    mem_wd = clr_q ? '0 : s11_row;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bmem[mem_wa] <= mem_wd;
    end
    if (adv) begin
      mem_rd_q <= bmem[addr_q[10]];
      fwd_val_q <= s11_row;
    end
  end

  // handshake and control
  assign adv = ~v_q[12] | out_ready_i;
  assign in_ready_o = adv & ~clr_q;
  assign out_valid_o = v_q[12];

  logic out_inr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_cnt_q == AW'(HIDDEN_MAX - 1)) begin
          clr_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (adv) begin
        v_q <= {v_q[11:1], in_valid_i & in_ready_o};
        fwd_q <= v_q[11] & inr_q[11] & (addr_q[11] == addr_q[10]);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_addr_q <= AW'({22'd0, hidden_index_i});
      s1_inr_q <= ({22'd0, hidden_index_i} < 32'(HIDDEN_MAX));
      s1_cp_q <= prev_cell_i;
      s1_cn_q <= new_cell_i;
      s1_ohg_q <= out_hidden_grad_i;
      s1_chg_q <= carried_hidden_grad_i;
      s1_cog_q <= cell_out_grad_i;
      s1_ccg_q <= carried_cell_grad_i;
      s1_gi_q <= input_gate_i;
      s1_gf_q <= forget_gate_i;
      s1_go_q <= output_gate_i;
      s1_gg_q <= cand_gate_i;

      addr_q[2] <= s1_addr_q;
      inr_q[2] <= s1_inr_q;
      for (int s = 3; s <= 11; s++) begin
        addr_q[s] <= addr_q[s-1];
        inr_q[s] <= inr_q[s-1];
      end

      cp_q[2] <= s1_cp_q;
      gi_q[2] <= s1_gis;
      gf_q[2] <= s1_gfs;
      gg_q[2] <= s1_gg_q;
      for (int s = 3; s <= 7; s++) begin
        cp_q[s] <= cp_q[s-1];
        gi_q[s] <= gi_q[s-1];
        gf_q[s] <= gf_q[s-1];
        gg_q[s] <= gg_q[s-1];
      end
      cs_q[2] <= s1_cs;
      for (int s = 3; s <= 6; s++) begin
        cs_q[s] <= cs_q[s-1];
      end
      s2_dh_q <= s1_dh;
      s2_neg_q <= s1_neg;
      s2_big_q <= s1_big;
      s2_tk_q <= s1_tk;
      s2_tprod_q <= s1_tprod;
      s2_pi_q <= s1_pi;
      s2_pf_q <= s1_pf;
      s2_po_q <= s1_po;
      s2_pg_q <= s1_pg;
      s2_pdct_q <= s1_pdct;

      ip_q[3] <= s2_ip;
      fp_q[3] <= s2_fp;
      op_q[3] <= s2_op;
      gc_q[3] <= s2_gc;
      for (int s = 4; s <= 9; s++) begin
        ip_q[s] <= ip_q[s-1];
        fp_q[s] <= fp_q[s-1];
        op_q[s] <= op_q[s-1];
        gc_q[s] <= gc_q[s-1];
      end
      s3_ct_q <= s2_ct;
      s3_dh_q <= s2_dh_q;
      dct_q[3] <= s2_dct;
      dct_q[4] <= dct_q[3];
      dct_q[5] <= dct_q[4];

      s4_pcc_q <= s3_pcc;
      s4_pcd_q <= s3_pcd;

      s5_tc_q <= s4_tc;
      do_q[5] <= s4_do;
      for (int s = 6; s <= 9; s++) begin
        do_q[s] <= do_q[s-1];
      end

      s6_ptd_q <= s5_ptd;
      s7_dc_q <= s6_dc;

      s8_pf_q <= s7_pf;
      s8_pcp_q <= s7_pcp;
      s8_pi_q <= s7_pi;
      s8_pg_q <= s7_pg;

      s9_df_q <= s8_df;
      s9_di_q <= s8_di;
      s9_dgc_q <= s8_dgc;
      dcp_q[9] <= s8_dcp;

      s10_q_q[0] <= s9_qi;
      s10_q_q[1] <= s9_qg;
      s10_q_q[2] <= s9_qf;
      s10_q_q[3] <= s9_qo;
      dcp_q[10] <= dcp_q[9];

      for (int g = 0; g < 5; g++) begin
        s11_res_q[g] <= s10_res[g];
      end
      s11_flag_q <= s10_flag;

      grad_pre_input_o <= s11_res_q[0];
      grad_pre_cand_o <= s11_res_q[1];
      grad_pre_forget_o <= s11_res_q[2];
      grad_pre_output_o <= s11_res_q[3];
      prev_cell_grad_o <= s11_res_q[4];
      bias_sum_input_o <= inr_q[11] ? s11_sum[0] : '0;
      bias_sum_cand_o <= inr_q[11] ? s11_sum[1] : '0;
      bias_sum_forget_o <= inr_q[11] ? s11_sum[2] : '0;
      bias_sum_output_o <= inr_q[11] ? s11_sum[3] : '0;
      saturated_o <= s11_flag;
      out_inr_q <= inr_q[11];
    end
  end

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_ready_o) else $error("request taken during clearing pass");

  a_pipe_empty_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (v_q == '0)) else $error("pipeline busy during clearing pass");

  a_clr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (32'(clr_cnt_q) < 32'(HIDDEN_MAX))) else $error("clear counter out of range");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[12] && !out_inr_q) |-> (bias_sum_input_o == 32'sd0 && bias_sum_cand_o == 32'sd0
      && bias_sum_forget_o == 32'sd0 && bias_sum_output_o == 32'sd0))
    else $error("bias sums nonzero for index out of range");
`endif

endmodule
`default_nettype wire
